@@ hw/rtl/smf_pkg.sv @@
// Shared types and constants of the 3x3 smoothing filter.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package smf_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Field widths
    localparam int PIX_W = 8;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int SUM_W = 13;                 // 28 * 255 fits
    localparam int PROD_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // floor(q / 7) = (q * DIV_MULT) >> DIV_SHIFT, exact for q < 5461
    localparam int DIV_MULT  = 4682;
    localparam int DIV_SHIFT = 15;

    // Result slots of one input pixel, in emission order
    localparam int EMIT_CENTER = 0;
    localparam int EMIT_RIGHT  = 1;
    localparam int EMIT_BOTTOM = 2;
    localparam int EMIT_N      = 3;

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [SUM_W-1:0] sum_t;

    // One window column: [0] row y-2, [1] row y-1, [2] row y
    typedef pix_t [2:0] win_col_t;

    // Item handed from the filter pipeline to the result emitter
    typedef struct packed {
        logic [EMIT_N-1:0] mask;
        logic              interior;
        logic              fend;
        col_t              x;
        row_t              y;
        sum_t              sum;
    } smf_item_t;

endpackage

@@ hw/rtl/smf_if.sv @@
// Handshake channels of the smoothing filter: pixels, results, config writes.
// Depends on smf_pkg for the payload types.
`timescale 1ns / 1ps

interface smf_pix_if;
    import smf_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface smf_res_if;
    import smf_pkg::*;
    logic valid;
    logic ready;
    pix_t pixel_out;
    col_t out_column;
    row_t out_row;
    logic run_last;
    logic frame_end;

    modport source (output valid, output pixel_out, output out_column, output out_row,
                    output run_last, output frame_end, input ready);
    modport sink   (input valid, input pixel_out, input out_column, input out_row,
                    input run_last, input frame_end, output ready);
endinterface

interface smf_cfg_if;
    import smf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/smf_col_cell.sv @@
// One column cell of the 3x3 window: holds three pixels, passes them on.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_col_cell
    import smf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     clear,
    input  logic     shift,
    input  win_col_t col_in,
    output win_col_t col_q
);

    win_col_t col_reg;
    win_col_t col_next;

    // Load the neighbor's column on shift, drop everything on restart
    always_comb
    begin
        col_next = col_reg;
        if (clear)
        begin
            col_next = '0;
        end
        else if (shift)
        begin
            col_next = col_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_q = col_reg;

endmodule

@@ hw/rtl/smf_line_store.sv @@
// Line store: one row of pixels, one write and one registered read a cycle.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_line_store
    import smf_pkg::*;
(
    input  logic clk,
    input  logic we,
    input  col_t waddr,
    input  pix_t wdata,
    input  logic re,
    input  col_t raddr,
    output pix_t rdata
);

    pix_t mem [MAX_WIDTH];
    pix_t rdata_reg;

    // Write the row entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read, forwarding a write to the same entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/smf_emitter.sv @@
// Result emitter: scales the window sum and sends the one to three results
// of a pixel, one per request. Depends on smf_pkg and smf_if.
`timescale 1ns / 1ps

module smf_emitter
    import smf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  smf_item_t   item,
    output logic        item_ready,
    smf_res_if.source   res
);

    logic              e_v_reg;
    logic [EMIT_N-1:0] e_mask_reg;
    pix_t              e_pix_reg;
    logic              e_fend_reg;
    col_t              e_x_reg;
    row_t              e_y_reg;

    logic [PROD_W-1:0] prod;
    pix_t              quot;
    logic              single;
    logic              fire;
    logic              load;

    // Divide by 28: drop two bits, then multiply by the reciprocal of 7
    assign prod = PROD_W'(item.sum[SUM_W-1:2]) * PROD_W'(DIV_MULT);
    assign quot = prod[DIV_SHIFT +: PIX_W];

    assign single     = (e_mask_reg & (e_mask_reg - 1'b1)) == '0;
    assign fire       = e_v_reg && res.ready;
    assign item_ready = !e_v_reg || (res.ready && single);
    assign load       = item_valid && item_ready && (item.mask != '0);

    // Hold the item until its last result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg    <= 1'b0;
            e_mask_reg <= '0;
        end
        else if (load)
        begin
            e_v_reg    <= 1'b1;
            e_mask_reg <= item.mask;
        end
        else if (fire)
        begin
            e_mask_reg <= e_mask_reg & (e_mask_reg - 1'b1);
            if (single)
            begin
                e_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            e_pix_reg  <= item.interior ? quot : '0;
            e_fend_reg <= item.fend;
            e_x_reg    <= item.x;
            e_y_reg    <= item.y;
        end
    end

    // Present the lowest pending result
    always_comb
    begin
        res.valid     = e_v_reg;
        res.run_last  = single;
        res.pixel_out = '0;
        res.frame_end = 1'b0;
        priority if (e_mask_reg[EMIT_CENTER])
        begin
            res.pixel_out  = e_pix_reg;
            res.out_column = e_x_reg - 1'b1;
            res.out_row    = e_y_reg - 1'b1;
        end
        else if (e_mask_reg[EMIT_RIGHT])
        begin
            res.out_column = e_x_reg;
            res.out_row    = e_y_reg - 1'b1;
        end
        else
        begin
            res.out_column = e_x_reg;
            res.out_row    = e_y_reg;
            res.frame_end  = e_fend_reg;
        end
    end

endmodule

@@ hw/rtl/smoothing_filter_3x3_unit.sv @@
// Top level of the streaming 3x3 smoothing filter.
// Depends on smf_pkg, smf_if, smf_col_cell, smf_line_store and smf_emitter.
`timescale 1ns / 1ps

// Usage
//   pixels  : input pixels in raster order, one request per pixel.
//   results : filtered pixels with their column and row; run_last marks the
//             last result of an input pixel, frame_end the bottom right pixel.
//   cfg     : writes image_width (index 0) or image_height (index 1); each
//             write restarts the frame. Write only while the filter is idle.
// Timing
//   A pixel's first result is valid once it has passed the stage 1 and
//   stage 2 registers and loaded the emitter. One pixel per cycle is taken
//   while the receiver takes results; a pixel with two or three results (the
//   last column and the bottom row) holds the emitter for each extra result,
//   so the bottom row runs slower: the emitter has a single result register.
// Reset
//   Counters and window clear at once; the line stores start undefined and
//   only ever feed border pixels, which are forced to zero, until written.
// Stall
//   While results wait, two more pixels move into the pipeline, then
//   pixels.ready drops until the receiver takes results again.
module smoothing_filter_3x3_unit
    import smf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    smf_pix_if.sink   pixels,
    smf_res_if.source results,
    smf_cfg_if.sink   cfg
);

    // Frame size and position
    col_t w_last_reg, w_last_next;
    row_t h_last_reg, h_last_next;
    col_t col_reg,    col_next;
    row_t row_reg,    row_next;
    logic restart;

    // Pipeline stage 1: line store read data arrives
    logic              s1_v_reg;
    pix_t              s1_px_reg;
    col_t              s1_x_reg;
    row_t              s1_y_reg;
    logic [EMIT_N-1:0] s1_mask_reg;
    logic              s1_interior_reg;
    logic              s1_fend_reg;

    // Pipeline stage 2: window sum
    logic      s2_v_reg;
    smf_item_t s2_item_reg;

    logic      accept;
    logic      s1_move, s1_free;
    logic      s2_move, s2_free;
    logic      emit_ready;

    pix_t      top_rd, mid_rd;
    win_col_t  col_new, col_m1, col_m2;
    sum_t      corners, edges, sum;
    logic [EMIT_N-1:0] mask;
    logic      x_last, y_last;
    logic [WIDTH_W-1:0]  cfg_w;
    logic [HEIGHT_W-1:0] cfg_h;

    // Handshakes along the pipeline
    assign s2_move       = s2_v_reg && (emit_ready || (s2_item_reg.mask == '0));
    assign s2_free       = !s2_v_reg || s2_move;
    assign s1_move       = s1_v_reg && s2_free;
    assign s1_free       = !s1_v_reg || s1_move;
    assign pixels.ready  = s1_free;
    assign accept        = pixels.valid && s1_free;
    assign cfg.ready     = 1'b1;
    assign restart       = cfg.valid &&
                           ((cfg.index == CFG_IMAGE_WIDTH) || (cfg.index == CFG_IMAGE_HEIGHT));

    // Clamp and hold the frame size as last column and last row
    assign cfg_w = cfg.data[WIDTH_W-1:0];
    assign cfg_h = cfg.data[HEIGHT_W-1:0];

    always_comb
    begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg.valid && (cfg.index == CFG_IMAGE_WIDTH))
        begin
            priority if (cfg_w == '0)
            begin
                w_last_next = '0;
            end
            else if (cfg_w > WIDTH_W'(MAX_WIDTH))
            begin
                w_last_next = COL_W'(MAX_WIDTH - 1);
            end
            else
            begin
                w_last_next = COL_W'(cfg_w - 1'b1);
            end
        end
        if (cfg.valid && (cfg.index == CFG_IMAGE_HEIGHT))
        begin
            priority if (cfg_h == '0)
            begin
                h_last_next = '0;
            end
            else if (cfg_h > HEIGHT_W'(MAX_HEIGHT))
            begin
                h_last_next = ROW_W'(MAX_HEIGHT - 1);
            end
            else
            begin
                h_last_next = ROW_W'(cfg_h - 1'b1);
            end
        end
    end

    // Decide which results the incoming pixel causes
    assign x_last = col_reg == w_last_reg;
    assign y_last = row_reg == h_last_reg;

    always_comb
    begin
        mask = '0;
        mask[EMIT_CENTER] = (col_reg != '0) && (row_reg != '0);
        mask[EMIT_RIGHT]  = x_last && (row_reg != '0);
        mask[EMIT_BOTTOM] = y_last;
    end

    // Advance the raster position, wrapping at the frame size
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (x_last)
            begin
                col_next = '0;
                row_next = y_last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg <= COL_W'(RESET_WIDTH - 1);
            h_last_reg <= ROW_W'(RESET_HEIGHT - 1);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Line stores: rows y-1 and y-2, read on accept, written when stage 1 moves
    smf_line_store u_prev (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_x_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    smf_line_store u_prev2 (
        .clk   (clk),
        .we    (s1_move),
        .waddr (s1_x_reg),
        .wdata (mid_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= pixels.pixel_in;
            s1_x_reg        <= col_reg;
            s1_y_reg        <= row_reg;
            s1_mask_reg     <= mask;
            s1_interior_reg <= (col_reg[COL_W-1:1] != '0) && (row_reg[ROW_W-1:1] != '0);
            s1_fend_reg     <= x_last;
        end
    end

    // Window: a chain of two column cells, columns x-1 and x-2
    always_comb
    begin
        col_new[0] = top_rd;
        col_new[1] = mid_rd;
        col_new[2] = s1_px_reg;
    end

    smf_col_cell u_cell_m1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (restart),
        .shift  (s1_move),
        .col_in (col_new),
        .col_q  (col_m1)
    );

    smf_col_cell u_cell_m2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (restart),
        .shift  (s1_move),
        .col_in (col_m1),
        .col_q  (col_m2)
    );

    // Weighted window sum: corners x1, edges x4, center x8
    assign corners = SUM_W'(col_m2[0]) + SUM_W'(col_m2[2]) + SUM_W'(top_rd)
                   + SUM_W'(s1_px_reg);
    assign edges   = SUM_W'(col_m2[1]) + SUM_W'(col_m1[0]) + SUM_W'(col_m1[2])
                   + SUM_W'(mid_rd);
    assign sum     = corners + (edges << 2) + (SUM_W'(col_m1[1]) << 3);

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_item_reg.mask     <= s1_mask_reg;
            s2_item_reg.interior <= s1_interior_reg;
            s2_item_reg.fend     <= s1_fend_reg;
            s2_item_reg.x        <= s1_x_reg;
            s2_item_reg.y        <= s1_y_reg;
            s2_item_reg.sum      <= sum;
        end
    end

    // Scale and send results
    smf_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s2_v_reg),
        .item       (s2_item_reg),
        .item_ready (emit_ready),
        .res        (results)
    );

endmodule
